// File: hdl/wio_pkg.sv
// ----------------------------------------------------------------------------
// wio_pkg
// Shared types, constants and the arctangent table for the wheel and gyro
// odometry block.
// ----------------------------------------------------------------------------
package wio_pkg;

  // angles in 1/256 degree
  localparam logic [16:0] DEG_FULL     = 17'd92160;
  localparam logic [16:0] DEG_HALF     = 17'd46080;
  localparam logic [16:0] DEG_QUARTER  = 17'd23040;
  localparam logic [16:0] DEG_3QUARTER = 17'd69120;
  localparam logic [31:0] DIV_FULL     = 32'd92160;
  localparam logic [31:0] DIV_FULL2    = 32'd184320;
  // multiple of the double circle, keeps the heading angle positive
  localparam logic [35:0] HEAD_BIAS    = 36'd12079595520;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] COS_EPS     = 34'sd10737;
  localparam logic signed [31:0] RAD_K       = 32'sd292818;
  localparam logic [47:0]        SAT47       = 48'h7FFF_FFFF_FFFF;

  localparam logic [2:0] REG_A_ANGLE = 3'd0;
  localparam logic [2:0] REG_A_DPR   = 3'd1;
  localparam logic [2:0] REG_A_RAD   = 3'd2;
  localparam logic [2:0] REG_B_ANGLE = 3'd3;
  localparam logic [2:0] REG_B_DPR   = 3'd4;
  localparam logic [2:0] REG_B_RAD   = 3'd5;
  localparam logic [2:0] REG_SCALE   = 3'd6;

  typedef enum logic [4:0] {
    U_TURN, U_CORD, U_MTRV, U_MARC, U_MARK, U_DIVR, U_DIVA, U_MEAN,
    U_MSCR, U_MSCA, U_HMOD, U_HTURN, U_HCORD, U_ROT1, U_ROT2, U_ROT3, U_ROT4
  } uop_e;

  typedef struct packed {
    logic accept;
    logic start;
    logic capture;
    logic load_out;
    logic wheel;
    uop_e uop;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic ok_r;
    logic ok_a;
  } sts_t;

  // atan(2^-i) in turns of 2^32
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/wio_cordic.sv
// ----------------------------------------------------------------------------
// wio_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, giving the
// cosine and sine of an angle in turns of 2^32 in Q30.
// ----------------------------------------------------------------------------
module wio_cordic #(
  parameter int unsigned ITER = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        angle_i,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o,
  output logic               done_o
);
  import wio_pkg::*;

  localparam int unsigned CW = $clog2(ITER);

  logic signed [33:0] x_q, y_q, z_q;
  logic signed [33:0] dx, dy, at;
  logic [31:0]        za;
  logic               flip, flip_q, busy_q, done_q;
  logic [CW-1:0]      cnt_q;

  // angles in the left half plane are folded by half a turn
  assign flip = angle_i[31] ^ angle_i[30];
  assign za   = angle_i ^ {flip, 31'b0};
  assign dx   = y_q >>> cnt_q;
  assign dy   = x_q >>> cnt_q;
  assign at   = $signed({2'b00, atan_turn(5'(cnt_q))});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        flip_q <= flip;
        x_q    <= CORDIC_GAIN;
        y_q    <= '0;
        z_q    <= $signed({{2{za[31]}}, za});
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (!z_q[33]) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + at;
        end
        if (cnt_q == CW'(ITER - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;
  assign done_o = done_q;

endmodule

// File: hdl/wio_div.sv
// ----------------------------------------------------------------------------
// wio_div
// Restoring divider, two quotient bits per cycle. Gives a 48-bit quotient
// saturated to 2^47-1 and the remainder of an 80 by 32 bit division.
// ----------------------------------------------------------------------------
module wio_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [79:0] num_i,
  input  logic [31:0] den_i,
  output logic [47:0] quo_o,
  output logic [31:0] rem_o,
  output logic        done_o
);
  import wio_pkg::*;

  localparam logic [4:0] LAST_STEP = 5'd23;

  logic [31:0] rem_q, den_q;
  logic [47:0] sh_q;
  logic [4:0]  cnt_q;
  logic        sat_q, busy_q, done_q;
  logic [32:0] r1, r1n, r2, r2n;
  logic        ge1, ge2;

  always_comb begin
    r1  = {rem_q, sh_q[47]};
    ge1 = r1 >= {1'b0, den_q};
    r1n = ge1 ? r1 - {1'b0, den_q} : r1;
    r2  = {r1n[31:0], sh_q[46]};
    ge2 = r2 >= {1'b0, den_q};
    r2n = ge2 ? r2 - {1'b0, den_q} : r2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= num_i[79:48];
        sat_q  <= num_i[79:48] >= den_i;
        sh_q   <= num_i[47:0];
        den_q  <= den_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= r2n[31:0];
        sh_q  <= {sh_q[45:0], ge1, ge2};
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign quo_o  = (sat_q || sh_q[47]) ? SAT47 : sh_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

// File: hdl/wio_dpath.sv
// ----------------------------------------------------------------------------
// wio_dpath
// Odometry datapath: configuration registers, sensor and pose state, a
// digit-serial multiplier, the shared divider and the shared CORDIC.
// ----------------------------------------------------------------------------
module wio_dpath #(
  parameter int unsigned ITER = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  wio_pkg::cmd_t cmd_i,
  output wio_pkg::sts_t sts_o,
  input  logic [207:0]  s_tdata_i,
  input  logic          s_tuser_i,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_index_i,
  input  logic [23:0]   cfg_data_i,
  output logic [119:0]  m_tdata_o
);
  import wio_pkg::*;

  // configuration
  logic [16:0]        ang_a_q, ang_b_q;
  logic [23:0]        dpr_a_q, dpr_b_q, scale_q;
  logic signed [23:0] rad_a_q, rad_b_q;
  // sensor and pose state
  logic [31:0]        last_a_q, last_b_q, last_imu_q;
  logic               primed_q;
  logic [39:0]        acc_right_q, acc_ahead_q;
  logic [31:0]        acc_head_q;
  // frame work registers
  logic signed [31:0] dlt_a_q, dlt_b_q, dpol_q;
  logic [31:0]        turn_q;
  logic signed [47:0] trv_q, trav_q, loc_r_q, loc_a_q;
  logic signed [63:0] arc_q;
  logic signed [48:0] sum_r_q, sum_a_q;
  logic [1:0]         nr_q, na_q, fault_q;
  logic [17:0]        hrem_q;
  logic [39:0]        t1_q;
  logic [119:0]       out_q;
  // multiplier
  logic signed [95:0] ma_q, macc_q, term;
  logic [31:0]        mb_q;
  logic [2:0]         mcnt_q;
  logic               mbusy_q, mdone_q;
  logic signed [4:0]  nib;
  logic signed [63:0] ma_in;
  logic signed [31:0] mb_in;
  // units
  logic               is_mul, is_div, is_cor;
  logic [79:0]        num_in;
  logic [31:0]        den_in;
  logic [47:0]        quo;
  logic [31:0]        rem;
  logic               div_done, cor_done;
  logic signed [33:0] cos_v, sin_v;
  // selection
  logic               w;
  logic [16:0]        ang_sel, ang_mod;
  logic [23:0]        dpr_sel;
  logic signed [23:0] rad_sel;
  logic signed [31:0] dlt_sel;
  logic [47:0]        trav_mag;
  logic [33:0]        cos_mag, sin_mag;
  logic signed [35:0] hv;
  logic [35:0]        hpos;
  logic signed [48:0] qs_r, qs_a;
  logic signed [47:0] mean_r, mean_a;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [47:0] r;
    if (v > $signed({16'b0, SAT47}))       r = $signed(SAT47);
    else if (v < -$signed({16'b0, SAT47})) r = -$signed(SAT47);
    else                                    r = v[47:0];
    return r;
  endfunction

  function automatic logic signed [47:0] mean(input logic signed [48:0] s,
                                              input logic [1:0] n);
    logic signed [48:0] h;
    h = (s + $signed({48'b0, s[48]})) >>> 1;
    if (n == 2'd0)      return '0;
    else if (n == 2'd1) return s[47:0];
    else                return h[47:0];
  endfunction

  always_comb begin
    w        = cmd_i.wheel;
    ang_sel  = w ? ang_b_q : ang_a_q;
    dpr_sel  = w ? dpr_b_q : dpr_a_q;
    rad_sel  = w ? rad_b_q : rad_a_q;
    dlt_sel  = w ? dlt_b_q : dlt_a_q;
    ang_mod  = (ang_sel >= DEG_FULL) ? ang_sel - DEG_FULL : ang_sel;
    trav_mag = trav_q[47] ? 48'(-trav_q) : 48'(trav_q);
    cos_mag  = cos_v[33] ? 34'(-cos_v) : 34'(cos_v);
    sin_mag  = sin_v[33] ? 34'(-sin_v) : 34'(sin_v);
    hv       = 36'sd46080 - ($signed({{4{acc_head_q[31]}}, acc_head_q}) <<< 1)
               + $signed({{4{dpol_q[31]}}, dpol_q});
    hpos     = 36'(hv) + HEAD_BIAS;
    qs_r     = (trav_q[47] ^ cos_v[33]) ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    qs_a     = (trav_q[47] ^ sin_v[33]) ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    mean_r   = mean(sum_r_q, nr_q);
    mean_a   = mean(sum_a_q, na_q);
    sts_o.ok_r = (ang_mod != DEG_QUARTER) && (ang_mod != DEG_3QUARTER) &&
                 ((cos_v > COS_EPS) || (cos_v < -COS_EPS));
    sts_o.ok_a = (ang_mod != '0) && (ang_mod != DEG_HALF) &&
                 ((sin_v > COS_EPS) || (sin_v < -COS_EPS));
    sts_o.done = mdone_q | div_done | cor_done;
  end

  // unit and operand selection
  always_comb begin
    is_mul = 1'b0;
    is_div = 1'b0;
    is_cor = 1'b0;
    ma_in  = '0;
    mb_in  = '0;
    num_in = '0;
    den_in = DIV_FULL;
    unique case (cmd_i.uop)
      U_TURN: begin
        is_div = 1'b1;
        num_in = {31'b0, ang_mod, 32'b0};
      end
      U_CORD, U_HCORD: is_cor = 1'b1;
      U_MTRV: begin
        is_mul = 1'b1;
        ma_in  = 64'(dlt_sel);
        mb_in  = $signed({8'b0, dpr_sel});
      end
      U_MARC: begin
        is_mul = 1'b1;
        ma_in  = 64'(rad_sel);
        mb_in  = dpol_q;
      end
      U_MARK: begin
        is_mul = 1'b1;
        ma_in  = arc_q;
        mb_in  = RAD_K;
      end
      U_DIVR: begin
        is_div = 1'b1;
        num_in = {2'b0, trav_mag, 30'b0};
        den_in = cos_mag[31:0];
      end
      U_DIVA: begin
        is_div = 1'b1;
        num_in = {2'b0, trav_mag, 30'b0};
        den_in = sin_mag[31:0];
      end
      U_MEAN: ;
      U_MSCR: begin
        is_mul = 1'b1;
        ma_in  = 64'(loc_r_q);
        mb_in  = $signed({8'b0, scale_q});
      end
      U_MSCA: begin
        is_mul = 1'b1;
        ma_in  = 64'(loc_a_q);
        mb_in  = $signed({8'b0, scale_q});
      end
      U_HMOD: begin
        is_div = 1'b1;
        num_in = {44'b0, hpos};
        den_in = DIV_FULL2;
      end
      U_HTURN: begin
        is_div = 1'b1;
        num_in = {30'b0, hrem_q, 32'b0};
        den_in = DIV_FULL2;
      end
      U_ROT1: begin
        is_mul = 1'b1;
        ma_in  = 64'(loc_r_q);
        mb_in  = cos_v[31:0];
      end
      U_ROT2: begin
        is_mul = 1'b1;
        ma_in  = 64'(loc_a_q);
        mb_in  = sin_v[31:0];
      end
      U_ROT3: begin
        is_mul = 1'b1;
        ma_in  = 64'(loc_r_q);
        mb_in  = sin_v[31:0];
      end
      U_ROT4: begin
        is_mul = 1'b1;
        ma_in  = 64'(loc_a_q);
        mb_in  = cos_v[31:0];
      end
      default: ;
    endcase
  end

  wio_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start && is_div),
    .num_i   (num_in),
    .den_i   (den_in),
    .quo_o   (quo),
    .rem_o   (rem),
    .done_o  (div_done)
  );

  wio_cordic #(.ITER(ITER)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start && is_cor),
    .angle_i (turn_q),
    .cos_o   (cos_v),
    .sin_o   (sin_v),
    .done_o  (cor_done)
  );

  // multiplier, one 4-bit digit of the second operand per cycle, top digit signed
  assign nib  = $signed({(mcnt_q == 3'd7) ? mb_q[3] : 1'b0, mb_q[3:0]});
  assign term = ma_q * nib;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
      mdone_q <= 1'b0;
      mcnt_q  <= '0;
    end else begin
      mdone_q <= 1'b0;
      if (cmd_i.start && is_mul) begin
        ma_q    <= 96'(ma_in);
        mb_q    <= mb_in;
        macc_q  <= '0;
        mcnt_q  <= '0;
        mbusy_q <= 1'b1;
      end else if (mbusy_q) begin
        macc_q <= macc_q + term;
        ma_q   <= ma_q <<< 4;
        mb_q   <= mb_q >> 4;
        mcnt_q <= mcnt_q + 1'b1;
        if (mcnt_q == 3'd7) begin
          mbusy_q <= 1'b0;
          mdone_q <= 1'b1;
        end
      end
    end
  end

  // configuration, sensor and pose state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_a_q     <= '0;
      dpr_a_q     <= '0;
      rad_a_q     <= '0;
      ang_b_q     <= DEG_QUARTER;
      dpr_b_q     <= '0;
      rad_b_q     <= '0;
      scale_q     <= 24'd65536;
      last_a_q    <= '0;
      last_b_q    <= '0;
      last_imu_q  <= '0;
      primed_q    <= 1'b0;
      acc_right_q <= '0;
      acc_ahead_q <= '0;
      acc_head_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_A_ANGLE: ang_a_q <= cfg_data_i[16:0];
          REG_A_DPR:   dpr_a_q <= cfg_data_i;
          REG_A_RAD:   rad_a_q <= cfg_data_i;
          REG_B_ANGLE: ang_b_q <= cfg_data_i[16:0];
          REG_B_DPR:   dpr_b_q <= cfg_data_i;
          REG_B_RAD:   rad_b_q <= cfg_data_i;
          REG_SCALE:   scale_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        if (s_tuser_i) begin
          acc_right_q <= s_tdata_i[135:96];
          acc_ahead_q <= s_tdata_i[175:136];
          acc_head_q  <= s_tdata_i[207:176];
        end else begin
          last_a_q   <= s_tdata_i[31:0];
          last_b_q   <= s_tdata_i[63:32];
          last_imu_q <= s_tdata_i[95:64];
          primed_q   <= 1'b1;
        end
      end
      if (cmd_i.capture && cmd_i.uop == U_ROT2) begin
        acc_right_q <= acc_right_q + t1_q - macc_q[69:30];
      end
      if (cmd_i.capture && cmd_i.uop == U_ROT4) begin
        acc_ahead_q <= acc_ahead_q + t1_q + macc_q[69:30];
        acc_head_q  <= acc_head_q - dpol_q;
      end
    end
  end

  // frame work registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      if (s_tuser_i) begin
        fault_q <= '0;
      end else begin
        // the first frame only primes, so every delta is zero
        dlt_a_q <= primed_q ? s_tdata_i[31:0] - last_a_q : '0;
        dlt_b_q <= primed_q ? s_tdata_i[63:32] - last_b_q : '0;
        dpol_q  <= primed_q ? last_imu_q - s_tdata_i[95:64] : '0;
        sum_r_q <= '0;
        sum_a_q <= '0;
        nr_q    <= '0;
        na_q    <= '0;
      end
    end
    if (cmd_i.capture) begin
      case (cmd_i.uop)
        U_TURN, U_HTURN: turn_q <= quo[31:0];
        U_MTRV: trv_q  <= macc_q[59:12];
        U_MARC: arc_q  <= macc_q[63:0];
        U_MARK: trav_q <= trv_q - macc_q[79:32];
        U_DIVR: begin
          sum_r_q <= sum_r_q + qs_r;
          nr_q    <= nr_q + 1'b1;
        end
        U_DIVA: begin
          sum_a_q <= sum_a_q + qs_a;
          na_q    <= na_q + 1'b1;
        end
        U_MEAN: begin
          loc_r_q <= mean_r;
          loc_a_q <= mean_a;
          fault_q <= {na_q == 2'd0, nr_q == 2'd0};
        end
        U_MSCR: loc_r_q <= sat48(macc_q[79:16]);
        U_MSCA: loc_a_q <= sat48(macc_q[79:16]);
        U_HMOD: hrem_q  <= rem[17:0];
        U_ROT1, U_ROT3: t1_q <= macc_q[69:30];
        default: ;
      endcase
    end
    if (cmd_i.load_out) begin
      out_q <= {6'b0, fault_q, acc_head_q, acc_ahead_q, acc_right_q};
    end
  end

  assign m_tdata_o = out_q;

endmodule

// File: hdl/wio_ctrl.sv
// ----------------------------------------------------------------------------
// wio_ctrl
// Sequencer for the odometry datapath: steps through the micro-operations of
// a frame, waits on the shared units and runs the stream handshakes.
// ----------------------------------------------------------------------------
module wio_ctrl #(
  parameter int unsigned NUM_WHEELS = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  input  logic          s_tuser_i,
  output logic          s_tready_o,
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  output wio_pkg::cmd_t cmd_o,
  input  wio_pkg::sts_t sts_i
);
  import wio_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_FIN} state_e;

  localparam logic LAST_WHEEL = (NUM_WHEELS >= 2);

  state_e state_q;
  uop_e   uop_q, nxt_uop;
  logic   wheel_q, nxt_wheel, out_valid_q, skip, advance, out_free;

  // wheel divides are skipped when the cosine or sine is too small
  assign skip = (uop_q == U_MEAN) || (uop_q == U_DIVR && !sts_i.ok_r) ||
                (uop_q == U_DIVA && !sts_i.ok_a);
  assign advance  = (state_q == S_ISSUE && skip) || (state_q == S_WAIT && sts_i.done);
  assign out_free = !out_valid_q || m_tready_i;

  always_comb begin
    nxt_wheel = wheel_q;
    nxt_uop   = uop_q;
    unique case (uop_q)
      U_TURN:  nxt_uop = U_CORD;
      U_CORD:  nxt_uop = U_MTRV;
      U_MTRV:  nxt_uop = U_MARC;
      U_MARC:  nxt_uop = U_MARK;
      U_MARK:  nxt_uop = U_DIVR;
      U_DIVR:  nxt_uop = U_DIVA;
      U_DIVA: begin
        if (wheel_q != LAST_WHEEL) begin
          nxt_wheel = 1'b1;
          nxt_uop   = U_TURN;
        end else begin
          nxt_uop = U_MEAN;
        end
      end
      U_MEAN:  nxt_uop = U_MSCR;
      U_MSCR:  nxt_uop = U_MSCA;
      U_MSCA:  nxt_uop = U_HMOD;
      U_HMOD:  nxt_uop = U_HTURN;
      U_HTURN: nxt_uop = U_HCORD;
      U_HCORD: nxt_uop = U_ROT1;
      U_ROT1:  nxt_uop = U_ROT2;
      U_ROT2:  nxt_uop = U_ROT3;
      U_ROT3:  nxt_uop = U_ROT4;
      default: nxt_uop = U_ROT4;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      uop_q       <= U_TURN;
      wheel_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // result register is refilled in the cycle the old item leaves
      out_valid_q <= (out_valid_q && !m_tready_i) || ((state_q == S_FIN) && out_free);
      unique case (state_q)
        S_IDLE: begin
          if (s_tvalid_i) begin
            if (s_tuser_i) begin
              state_q <= S_FIN;
            end else begin
              uop_q   <= U_TURN;
              wheel_q <= 1'b0;
              state_q <= S_ISSUE;
            end
          end
        end
        S_ISSUE, S_WAIT: begin
          if (advance) begin
            if (uop_q == U_ROT4) begin
              state_q <= S_FIN;
            end else begin
              uop_q   <= nxt_uop;
              wheel_q <= nxt_wheel;
              state_q <= S_ISSUE;
            end
          end else if (state_q == S_ISSUE) begin
            state_q <= S_WAIT;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.accept   = s_tvalid_i && (state_q == S_IDLE);
    cmd_o.start    = (state_q == S_ISSUE) && !skip;
    cmd_o.capture  = (state_q == S_WAIT && sts_i.done) ||
                     (state_q == S_ISSUE && uop_q == U_MEAN);
    cmd_o.load_out = (state_q == S_FIN) && out_free;
    cmd_o.wheel    = wheel_q;
    cmd_o.uop      = uop_q;
  end

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = out_valid_q;

  a_no_done_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> !sts_i.done)
    else $error("unit finished right after start");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || m_tready_i))
    else $error("result overwritten before it was taken");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> (state_q != S_IDLE))
    else $error("sequencer idle after accepting an item");

  a_no_start_and_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.start && cmd_o.capture))
    else $error("start and capture in the same cycle");

endmodule

// File: hdl/wheel_imu_odometry.sv
// ----------------------------------------------------------------------------
// wheel_imu_odometry
// Dead reckoning from two tracking wheels and a gyro heading.
// ----------------------------------------------------------------------------
// The slave stream takes one item per sensor frame (tuser 0) or pose load
// (tuser 1); the master stream returns one pose item for each. The config
// channel writes one register per handshake and is always ready; write it
// only while no item is in flight.
// A sensor frame steps through its micro-operations from accept to result, and
// the next item is accepted only after that. With two wheels the time is set
// by the shared divider (two quotient bits a cycle, up to eight divides per
// frame), the CORDIC (three runs) and the multiplier (one 4-bit digit a cycle,
// twelve products). A pose load goes from accept straight to the finish state,
// which loads the output register once it is free.
// Results sit in an output register, so a new item is accepted while a result
// waits; a finished item holds until the receiver takes the previous one.
// After reset the pose, heading and stored readings are zero, the first frame
// only primes the readings and the registers hold their reset values.
// ----------------------------------------------------------------------------
module wheel_imu_odometry #(
  parameter int unsigned NUM_WHEELS      = 2,
  parameter int unsigned TRIG_ITERATIONS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // wheel_a_revs, wheel_b_revs, imu_rotation, new_right, new_ahead, new_heading
  input  logic [207:0] s_axis_tdata,
  // cmd
  input  logic         s_axis_tuser,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pose_right, pose_ahead, field_heading, axis_fault, zero fill
  output logic [119:0] m_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [23:0]  cfg_data_i
);
  import wio_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  wio_ctrl #(.NUM_WHEELS(NUM_WHEELS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tuser_i  (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  wio_dpath #(.ITER(TRIG_ITERATIONS)) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .m_tdata_o   (m_axis_tdata)
  );

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level bench for the wheel and gyro odometry block. Sensor frames and
// pose loads go in through the slave stream; a pose model in the bench works
// out each expected pose no directed row gives; every returned item is
// compared field by field over several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import wio_pkg::*;

  localparam int          ITEMS_PER_PHASE = 112;
  localparam int          NUM_PHASES      = 8;
  localparam int          CYCLE_LIMIT     = 4000000;
  localparam longint      POS_SAT         = 64'h7FFF_FFFF_FFFF;
  localparam logic        CMD_FRAME       = 1'b0;
  localparam logic        CMD_LOAD        = 1'b1;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  typedef struct packed {
    logic [39:0] right;
    logic [39:0] ahead;
    logic [31:0] heading;
    logic [1:0]  fault;
  } pose_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] wheel_a;
    logic [31:0] wheel_b;
    logic [31:0] gyro;
    logic [39:0] new_right;
    logic [39:0] new_ahead;
    logic [31:0] new_heading;
  } frame_t;

  typedef struct packed {
    frame_t frame;
    logic   typed;
    pose_t  pose;
  } dir_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic [207:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [119:0] m_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i;
  logic [23:0]  cfg_data_i;

  wheel_imu_odometry u_top (.*);

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // atan(2^-i) in turns of 2^32
  longint atan_tab [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  // pose model state
  logic [16:0] mdl_angle [2];
  logic [23:0] mdl_dpr   [2];
  logic [23:0] mdl_rad   [2];
  logic [23:0] mdl_scale;
  logic [31:0] mdl_last  [2];
  logic [31:0] mdl_last_gyro;
  logic [39:0] mdl_right;
  logic [39:0] mdl_ahead;
  logic [31:0] mdl_heading;
  logic        mdl_primed;

  pose_t  pose_q [$];
  int     errors;
  int     cycles;
  idle_e  idle_mode;
  int     hold_cycles;

  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    $display("mismatch %s: expected %h got %h", what, want, got);
    errors++;
  endtask

  // floor(a * k / 2^s)
  function automatic longint mul_floor(input longint a, input longint k, input int s);
    longint hi;
    longint lo;
    hi = a >>> 32;
    lo = a & 64'hFFFF_FFFF;
    return hi * k * (longint'(1) << (32 - s)) + ((lo * k) >>> s);
  endfunction

  function automatic longint clamp47(input longint v);
    if (v > POS_SAT) return POS_SAT;
    if (v < -POS_SAT) return -POS_SAT;
    return v;
  endfunction

  function automatic logic [31:0] angle_turns(input longint v, input longint full);
    longint      r;
    logic [63:0] u;
    r = v % full;
    if (r < 0) r += full;
    u = r;
    u = (u << 32) / full;
    return u[31:0];
  endfunction

  task automatic trig_q30(input logic [31:0] a, output longint c, output longint s);
    logic   flip;
    logic [31:0] d;
    longint x, y, z, dx, dy;
    d = a - 32'h4000_0000;
    flip = d < 32'h8000_0000;
    if (flip) a = a ^ 32'h8000_0000;
    z = longint'($signed(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint div_by_trig(input longint n, input longint d);
    logic        neg;
    logic [63:0] un, ud, qi, rem, q;
    neg = (n < 0) != (d < 0);
    un = (n < 0) ? 64'(-n) : 64'(n);
    ud = (d < 0) ? 64'(-d) : 64'(d);
    qi = un / ud;
    rem = un % ud;
    if (qi >= (64'd1 << 17)) q = POS_SAT;
    else q = (qi << 30) + (rem << 30) / ud;
    if (q > POS_SAT) q = POS_SAT;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  task automatic predict_pose(input frame_t f, output pose_t p);
    logic [31:0] cur [2];
    logic [31:0] d32;
    longint dpol, sum_r, sum_a, loc_r, loc_a, cr, sr, dr, da;
    longint ang, dpr, rad, delta, trav, c, s;
    int     nr, na;
    p.fault = 2'b00;
    if (f.cmd == CMD_LOAD) begin
      mdl_right = f.new_right;
      mdl_ahead = f.new_ahead;
      mdl_heading = f.new_heading;
    end else begin
      cur[0] = f.wheel_a;
      cur[1] = f.wheel_b;
      if (!mdl_primed) begin
        mdl_last[0] = cur[0];
        mdl_last[1] = cur[1];
        mdl_last_gyro = f.gyro;
        mdl_primed = 1'b1;
      end
      d32 = mdl_last_gyro - f.gyro;
      dpol = longint'($signed(d32));
      sum_r = 0; sum_a = 0; nr = 0; na = 0; loc_r = 0; loc_a = 0;
      for (int w = 0; w < 2; w++) begin
        ang = longint'(mdl_angle[w]) % 92160;
        dpr = longint'(mdl_dpr[w]);
        rad = longint'($signed(mdl_rad[w]));
        d32 = cur[w] - mdl_last[w];
        delta = longint'($signed(d32));
        trav = ((delta * dpr) >>> 12) - mul_floor(rad * dpol, 292818, 32);
        trig_q30(angle_turns(ang, 92160), c, s);
        if (ang % 46080 != 23040 && (c > 10737 || c < -10737)) begin
          sum_r += div_by_trig(trav, c);
          nr++;
        end
        if (ang % 46080 != 0 && (s > 10737 || s < -10737)) begin
          sum_a += div_by_trig(trav, s);
          na++;
        end
      end
      if (nr != 0) loc_r = sum_r / nr; else p.fault[0] = 1'b1;
      if (na != 0) loc_a = sum_a / na; else p.fault[1] = 1'b1;
      loc_r = clamp47(mul_floor(loc_r, longint'(mdl_scale), 16));
      loc_a = clamp47(mul_floor(loc_a, longint'(mdl_scale), 16));
      trig_q30(angle_turns(46080 - 2 * longint'($signed(mdl_heading)) + dpol, 184320),
               cr, sr);
      dr = mul_floor(loc_r, cr, 30) - mul_floor(loc_a, sr, 30);
      da = mul_floor(loc_r, sr, 30) + mul_floor(loc_a, cr, 30);
      mdl_right = mdl_right + dr[39:0];
      mdl_ahead = mdl_ahead + da[39:0];
      mdl_heading = mdl_heading - dpol[31:0];
      mdl_last[0] = cur[0];
      mdl_last[1] = cur[1];
      mdl_last_gyro = f.gyro;
    end
    p.right = mdl_right;
    p.ahead = mdl_ahead;
    p.heading = mdl_heading;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_frame(input frame_t f, input logic typed, input pose_t want);
    pose_t p;
    int    idle_pct;
    idle_pct = (idle_mode == IDLE_BOTH) ? 9 : 73;
    if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) begin
      while ($urandom_range(0, 99) < idle_pct) begin
        s_axis_tvalid = 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = f.cmd;
    s_axis_tdata = {f.new_heading, f.new_ahead, f.new_right, f.gyro, f.wheel_b, f.wheel_a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_pose(f, p);
    pose_q = {pose_q, (typed ? want : p)};
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_A_ANGLE: mdl_angle[0] = val[16:0];
      REG_A_DPR:   mdl_dpr[0] = val;
      REG_A_RAD:   mdl_rad[0] = val;
      REG_B_ANGLE: mdl_angle[1] = val[16:0];
      REG_B_DPR:   mdl_dpr[1] = val;
      REG_B_RAD:   mdl_rad[1] = val;
      REG_SCALE:   mdl_scale = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    while (pose_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  // receiver side
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_mode == IDLE_RECV) begin
      m_axis_tready <= $urandom_range(0, 99) >= 73;
    end else if (idle_mode == IDLE_BOTH) begin
      m_axis_tready <= $urandom_range(0, 99) >= 9;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    pose_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[39:0], m_axis_tdata[79:40], m_axis_tdata[111:80],
             m_axis_tdata[113:112]};
      if (pose_q.size() == 0) begin
        report("unexpected item", 64'd0, 64'(got.right));
      end else begin
        want = pose_q.pop_front();
        if (got.right !== want.right) report("pose_right", 64'(want.right), 64'(got.right));
        if (got.ahead !== want.ahead) report("pose_ahead", 64'(want.ahead), 64'(got.ahead));
        if (got.heading !== want.heading)
          report("field_heading", 64'(want.heading), 64'(got.heading));
        if (got.fault !== want.fault) report("axis_fault", 64'(want.fault), 64'(got.fault));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic frame_t random_frame(inout logic [31:0] ga, inout logic [31:0] gb,
                                          inout logic [31:0] gg);
    frame_t f;
    int     pick;
    f = $bits(frame_t)'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom()});
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      f.cmd = CMD_LOAD;
      if (pick < 4) begin
        f.new_right = 40'($signed(20'($urandom())));
        f.new_ahead = 40'($signed(20'($urandom())));
        f.new_heading = 32'($signed(18'($urandom())));
      end
    end else begin
      f.cmd = CMD_FRAME;
      if (pick >= 15) begin
        f.wheel_a = ga + 32'($signed(13'($urandom())));
        f.wheel_b = gb + 32'($signed(13'($urandom())));
        f.gyro = gg + 32'($signed(12'($urandom())));
      end
      ga = f.wheel_a;
      gb = f.wheel_b;
      gg = f.gyro;
    end
    return f;
  endfunction

  dir_row_t    dir_rows [11];
  logic [23:0] phase_cfg [NUM_PHASES][7];

  initial begin
    frame_t      f;
    logic [31:0] ga, gb, gg;
    errors = 0;
    cycles = 0;
    hold_cycles = 0;
    idle_mode = IDLE_NONE;
    rst_ni = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_A_ANGLE;
    cfg_data_i = '0;
    mdl_angle[0] = 17'd0;     mdl_dpr[0] = '0; mdl_rad[0] = '0;
    mdl_angle[1] = DEG_QUARTER; mdl_dpr[1] = '0; mdl_rad[1] = '0;
    mdl_scale = 24'd65536;
    mdl_last[0] = '0; mdl_last[1] = '0; mdl_last_gyro = '0;
    mdl_right = '0; mdl_ahead = '0; mdl_heading = '0; mdl_primed = 1'b0;
    ga = '0; gb = '0; gg = '0;

    // wheel_a, wheel_b, gyro, right, ahead, heading | typed | expected pose
    dir_rows = '{
      // first frame only primes
      '{'{CMD_FRAME, 32'd0, 32'd0, 32'd0, 40'd0, 40'd0, 32'd0}, 1'b1,
        '{40'd0, 40'd0, 32'd0, 2'd0}},
      // zero distance per rev: no travel
      '{'{CMD_FRAME, 32'd1000, 32'd2000, 32'd0, 40'd0, 40'd0, 32'd0}, 1'b1,
        '{40'd0, 40'd0, 32'd0, 2'd0}},
      // gyro turns 90 deg clockwise, heading follows
      '{'{CMD_FRAME, 32'd1000, 32'd2000, 32'd23040, 40'd0, 40'd0, 32'd0}, 1'b1,
        '{40'd0, 40'd0, 32'd23040, 2'd0}},
      '{'{CMD_LOAD, 32'd0, 32'd0, 32'd0, 40'h7F_FFFF_FFFF, 40'h80_0000_0000, 32'h7FFF_FFFF},
        1'b1, '{40'h7F_FFFF_FFFF, 40'h80_0000_0000, 32'h7FFF_FFFF, 2'd0}},
      '{'{CMD_LOAD, '1, '1, '1, 40'h80_0000_0000, 40'h7F_FFFF_FFFF, 32'h8000_0000},
        1'b1, '{40'h80_0000_0000, 40'h7F_FFFF_FFFF, 32'h8000_0000, 2'd0}},
      '{'{CMD_LOAD, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 40'h55_5555_5555,
          40'hAA_AAAA_AAAA, 32'h5555_5555}, 1'b1,
        '{40'h55_5555_5555, 40'hAA_AAAA_AAAA, 32'h5555_5555, 2'd0}},
      '{'{CMD_LOAD, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 40'hAA_AAAA_AAAA,
          40'h55_5555_5555, 32'hAAAA_AAAA}, 1'b1,
        '{40'hAA_AAAA_AAAA, 40'h55_5555_5555, 32'hAAAA_AAAA, 2'd0}},
      // counter wrap on wheels and gyro
      '{'{CMD_FRAME, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 40'd0, 40'd0, 32'd0},
        1'b0, '0},
      '{'{CMD_FRAME, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 40'd0, 40'd0, 32'd0},
        1'b0, '0},
      '{'{CMD_LOAD, 32'd0, 32'd0, 32'd0, 40'd0, 40'd0, 32'd0}, 1'b1,
        '{40'd0, 40'd0, 32'd0, 2'd0}},
      '{'{CMD_FRAME, '1, '1, '1, '1, '1, '1}, 1'b0, '0}
    };

    // angle A, dpr A, radius A, angle B, dpr B, radius B, scale
    phase_cfg[0] = '{24'd0, 24'd4096, 24'd0, 24'd23040, 24'd4096, 24'd0, 24'd65536};
    phase_cfg[1] = '{24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom()),
                     24'($urandom()), 24'($urandom()), 24'($urandom())};
    // both wheels on the ahead axis: right axis empty
    phase_cfg[2] = '{24'd23040, 24'hFF_FFFF, 24'h7F_FFFF, 24'd69120, 24'hFF_FFFF,
                     24'h80_0000, 24'hFF_FFFF};
    // both wheels on the right axis: ahead axis empty, zero scale
    phase_cfg[3] = '{24'd0, 24'd70000, 24'd300000, 24'd46080, 24'd90000, 24'hF0_0000, 24'd0};
    // cosine close to zero
    phase_cfg[4] = '{24'd23039, 24'd200000, 24'd5000, 24'd23041, 24'd150000, 24'hFF_F000,
                     24'd131072};
    // angle B past a full circle, angle A just below one
    phase_cfg[5] = '{24'd92159, 24'd65536, 24'h00_8000, 24'h01_FFFF, 24'd32768, 24'h80_0000,
                     24'd65536};
    phase_cfg[6] = '{24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom()),
                     24'($urandom()), 24'($urandom()), 24'($urandom())};
    phase_cfg[7] = '{24'd11520, 24'd100000, 24'd40000, 24'd57600, 24'd120000, 24'd2000,
                     24'd98304};

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_frame(dir_rows[i].frame, dir_rows[i].typed, dir_rows[i].pose);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      for (int r = 0; r < 7; r++) write_reg(3'(r), phase_cfg[ph][r]);
      idle_mode = idle_e'(ph % 4);
      if (ph == NUM_PHASES - 1) hold_cycles = 3000;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        f = random_frame(ga, gb, gg);
        send_frame(f, 1'b0, '0);
      end
      drain();
    end

    idle_mode = IDLE_NONE;
    repeat (20) @(negedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
